### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with a synchronous low reset.
// Define ASSERT_OFF to compile every use down to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every rising edge of clk outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");

// Check that cond is never true at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen: %m");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/mbf_pkg.sv
// ----------------------------------------------------------------------------
// mbf_pkg
// Sizes, codes, word types and pointer helpers of the message byte FIFO.
// ----------------------------------------------------------------------------
package mbf_pkg;

    localparam int BUF_BYTES    = 2048;
    localparam int MAX_MESSAGES = 64;
    localparam int MAX_READ     = 64;

    localparam int BYTE_AW = $clog2(BUF_BYTES);
    localparam int MSG_AW  = $clog2(MAX_MESSAGES);
    localparam int LEN_W   = $clog2(BUF_BYTES + 1);
    localparam int CNT_W   = $clog2(MAX_MESSAGES + 1);
    localparam int READ_W  = $clog2(MAX_READ + 1);

    // Field widths of the port words.
    localparam int MAXL_W = 7;
    localparam int PEND_W = 12;

    // Depths of the command and result queues.
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic       REQ_WRITE   = 1'b0;
    localparam logic       REQ_READ    = 1'b1;
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        data_byte;
        logic              byte_valid;
        logic              end_of_message;
        logic [MAXL_W-1:0] max_len;
    } t_in_word;

    typedef struct packed {
        logic              is_read;
        logic [7:0]        data_byte;
        logic              byte_valid;
        logic              end_of_message;
        logic [READ_W-1:0] max_len;
    } t_cmd;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              out_valid;
        logic              last;
        logic              message_done;
        logic [1:0]        status;
        logic [PEND_W-1:0] pending_bytes;
        logic              queue_empty;
    } t_result;

    function automatic logic [BYTE_AW-1:0] byte_inc(input logic [BYTE_AW-1:0] p);
        return (p == BYTE_AW'(BUF_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [MSG_AW-1:0] msg_inc(input logic [MSG_AW-1:0] p);
        return (p == MSG_AW'(MAX_MESSAGES - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

### src/mbf_front.sv
// ----------------------------------------------------------------------------
// mbf_front
// Accept input words, classify them into commands and queue them for the engine.
// ----------------------------------------------------------------------------
module mbf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbf_pkg::t_in_word i_word,
    output logic              o_full,
    output logic              o_valid,
    output mbf_pkg::t_cmd     o_cmd,
    input  logic              i_take
);
    import mbf_pkg::*;

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr, n_wr;
    logic [CQ_AW-1:0] r_rd, n_rd;
    logic [CQ_CW-1:0] r_cnt, n_cnt;
    t_cmd             w_cmd;
    logic             w_put;
    logic             w_get;

    // Saturate the read length here at MAX_READ so the engine never sees a larger count.
    always_comb begin
        w_cmd.is_read        = (i_word.req_type == REQ_READ);
        w_cmd.data_byte      = i_word.data_byte;
        w_cmd.byte_valid     = i_word.byte_valid;
        w_cmd.end_of_message = i_word.end_of_message;
        if (i_word.max_len > MAXL_W'(MAX_READ)) begin
            w_cmd.max_len = READ_W'(MAX_READ);
        end else begin
            w_cmd.max_len = READ_W'(i_word.max_len);
        end
    end

    assign o_full  = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_put   = i_push && !o_full;
    assign w_get   = i_take && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_put) begin
            n_wr = (r_wr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_get) begin
            n_rd = (r_rd == CQ_AW'(CQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_put, w_get})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

endmodule

### src/mbf_engine.sv
// ----------------------------------------------------------------------------
// mbf_engine
// Carry out queued commands against the byte store and the message length table.
// ----------------------------------------------------------------------------
module mbf_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mbf_pkg::t_cmd    i_cmd,
    output logic             o_take,
    output logic             o_push,
    output mbf_pkg::t_result o_res,
    input  logic             i_full
);
    import mbf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [7:0]       byte_mem [BUF_BYTES];
    logic [LEN_W-1:0] len_mem  [MAX_MESSAGES];

    logic [1:0]         r_state,    n_state;
    logic [MSG_AW-1:0]  r_head,     n_head;
    logic [MSG_AW-1:0]  r_tail,     n_tail;
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [BYTE_AW-1:0] r_rd_ptr,   n_rd_ptr;
    logic [BYTE_AW-1:0] r_wr_ptr,   n_wr_ptr;
    logic [LEN_W-1:0]   r_used,     n_used;
    logic [LEN_W-1:0]   r_offset,   n_offset;
    logic [LEN_W-1:0]   r_open_len, n_open_len;
    logic [LEN_W-1:0]   r_head_len, n_head_len;
    logic [READ_W-1:0]  r_maxl,     n_maxl;
    logic [READ_W-1:0]  r_left,     n_left;
    logic [7:0]         r_rd_data;
    logic [LEN_W-1:0]   r_len_next;

    logic               w_byte_we;
    logic               w_len_we;
    logic [LEN_W-1:0]   w_open_after;
    logic [LEN_W-1:0]   w_rem;
    logic [LEN_W-1:0]   w_maxl_ext;
    logic [LEN_W-1:0]   w_take;
    logic [LEN_W-1:0]   w_off1;
    logic [LEN_W-1:0]   w_pend;

    assign w_open_after = i_cmd.byte_valid ? r_open_len + 1'b1 : r_open_len;
    assign w_rem        = r_head_len - r_offset;
    assign w_maxl_ext   = LEN_W'(r_maxl);
    assign w_take       = (w_rem < w_maxl_ext) ? w_rem : w_maxl_ext;
    assign w_off1       = r_offset + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_used     = r_used;
        n_offset   = r_offset;
        n_open_len = r_open_len;
        n_head_len = r_head_len;
        n_maxl     = r_maxl;
        n_left     = r_left;
        w_byte_we  = 1'b0;
        w_len_we   = 1'b0;
        o_take     = 1'b0;
        o_push     = 1'b0;
        o_res      = '0;
        w_pend     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid && !i_full) begin
                    o_take = 1'b1;
                    if (!i_cmd.is_read) begin
                        o_push     = 1'b1;
                        o_res.last = 1'b1;
                        if ((i_cmd.byte_valid && r_used == LEN_W'(BUF_BYTES)) ||
                            (i_cmd.end_of_message &&
                             r_count == CNT_W'(MAX_MESSAGES))) begin
                            o_res.status = STAT_FULL;
                        end else begin
                            o_res.status = STAT_OK;
                            if (i_cmd.byte_valid) begin
                                w_byte_we  = 1'b1;
                                n_wr_ptr   = byte_inc(r_wr_ptr);
                                n_used     = r_used + 1'b1;
                                n_open_len = w_open_after;
                            end
                            if (i_cmd.end_of_message) begin
                                w_len_we   = 1'b1;
                                n_tail     = msg_inc(r_tail);
                                n_count    = r_count + 1'b1;
                                n_open_len = '0;
                                if (r_count == '0) begin
                                    n_head_len = w_open_after;
                                end
                            end
                        end
                    end else if (r_count == '0) begin
                        o_push       = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.status = STAT_EMPTY;
                    end else begin
                        n_maxl  = i_cmd.max_len;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                if (w_take == '0) begin
                    if (!i_full) begin
                        o_push             = 1'b1;
                        o_res.last         = 1'b1;
                        o_res.status       = STAT_OK;
                        o_res.message_done = (w_rem == '0);
                        if (w_rem == '0) begin
                            n_head     = msg_inc(r_head);
                            n_count    = r_count - 1'b1;
                            n_offset   = '0;
                            n_head_len = r_len_next;
                        end
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_left  = READ_W'(w_take);
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                if (!i_full) begin
                    o_push          = 1'b1;
                    o_res.out_byte  = r_rd_data;
                    o_res.out_valid = 1'b1;
                    o_res.status    = STAT_OK;
                    o_res.last      = (r_left == READ_W'(1));
                    n_rd_ptr        = byte_inc(r_rd_ptr);
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end
                    if (w_off1 >= r_head_len) begin
                        o_res.message_done = 1'b1;
                        n_head     = msg_inc(r_head);
                        n_count    = r_count - 1'b1;
                        n_offset   = '0;
                        n_head_len = r_len_next;
                    end else begin
                        n_offset = w_off1;
                    end
                    n_left = r_left - 1'b1;
                    if (r_left == READ_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Report the head message as it stands once this result is applied.
        if (n_count != '0) begin
            w_pend = n_head_len - n_offset;
        end
        o_res.pending_bytes = PEND_W'(w_pend);
        o_res.queue_empty   = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_used     <= '0;
            r_offset   <= '0;
            r_open_len <= '0;
            r_head_len <= '0;
            r_left     <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_used     <= n_used;
            r_offset   <= n_offset;
            r_open_len <= n_open_len;
            r_head_len <= n_head_len;
            r_left     <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_maxl <= n_maxl;
    end

    // Byte store: one write port, one registered read that tracks the read pointer.
    always_ff @(posedge i_clk) begin
        if (w_byte_we) begin
            byte_mem[r_wr_ptr] <= i_cmd.data_byte;
        end
        r_rd_data <= byte_mem[n_rd_ptr];
    end

    // Length table: prefetch the length of the message behind the head.
    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            len_mem[r_tail] <= w_open_after;
        end
        r_len_next <= len_mem[msg_inc(r_head)];
    end

endmodule

### src/mbf_out_queue.sv
// ----------------------------------------------------------------------------
// mbf_out_queue
// Hold result words until the consumer pops them.
// ----------------------------------------------------------------------------
module mbf_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mbf_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    output mbf_pkg::t_result o_res,
    input  logic             i_pop
);
    import mbf_pkg::*;

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr, n_wr;
    logic [RQ_AW-1:0] r_rd, n_rd;
    logic [RQ_CW-1:0] r_cnt, n_cnt;
    logic             w_put;
    logic             w_get;

    assign o_full  = (r_cnt == RQ_CW'(RQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rd];
    assign w_put   = i_push && !o_full;
    assign w_get   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_put) begin
            n_wr = (r_wr == RQ_AW'(RQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_get) begin
            n_rd = (r_rd == RQ_AW'(RQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({w_put, w_get})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

### src/message_boundary_byte_fifo.sv
// ----------------------------------------------------------------------------
// message_boundary_byte_fifo
// Byte FIFO that keeps message boundaries: build, queue and read out messages.
// ----------------------------------------------------------------------------
// A write word appends one byte to the open message and, with the end flag,
// closes it and queues it; every write returns one word with status ok, or
// full (and changes nothing) when the byte store or the message table has no
// room. A read word returns up to max_len bytes (saturated at 64) from the
// head message only, one result word per byte, continuing where an earlier
// read stopped; a read of an empty queue, or one that moves no byte, returns
// a single word. A read that moves bytes pops its command, sizes the read
// from the head length, then returns one byte per cycle off the registered
// byte-store read port while the result queue has room. A four-word command
// queue in front and a four-word result queue behind let both sides stall
// on their own. No clearing pass after reset: stores are only read where
// written.
`include "assert_macros.svh"

module message_boundary_byte_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    input  logic [6:0]  i_max_len,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_last,
    output logic        o_message_done,
    output logic [1:0]  o_status,
    output logic [11:0] o_pending_bytes,
    output logic        o_queue_empty
);
    import mbf_pkg::*;

    t_in_word w_in;
    t_cmd     w_cmd;
    logic     w_cmd_valid;
    logic     w_cmd_take;
    t_result  w_res;
    logic     w_res_push;
    logic     w_res_full;
    t_result  w_out;

    // Pack the input word fields.
    assign w_in.req_type       = i_req_type;
    assign w_in.data_byte      = i_data_byte;
    assign w_in.byte_valid     = i_byte_valid;
    assign w_in.end_of_message = i_end_of_message;
    assign w_in.max_len        = i_max_len;

    // Front: accept and classify words.
    mbf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (w_in),
        .o_full  (full),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd),
        .i_take  (w_cmd_take)
    );

    // Back: run commands against the stores.
    mbf_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cmd_valid),
        .i_cmd   (w_cmd),
        .o_take  (w_cmd_take),
        .o_push  (w_res_push),
        .o_res   (w_res),
        .i_full  (w_res_full)
    );

    // Result queue: hold words for the consumer.
    mbf_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .o_res   (w_out),
        .i_pop   (pop)
    );

    // Unpack the result word onto its ports.
    assign o_out_byte      = w_out.out_byte;
    assign o_out_valid     = w_out.out_valid;
    assign o_last          = w_out.last;
    assign o_message_done  = w_out.message_done;
    assign o_status        = w_out.status;
    assign o_pending_bytes = w_out.pending_bytes;
    assign o_queue_empty   = w_out.queue_empty;

    // The engine only pushes a result when the result queue has room.
    `ASSERT_NEVER(a_push_into_full, i_clk, i_rst_n, w_res_push && w_res_full)
    // Error results never carry a byte.
    `ASSERT_NEVER(a_err_no_byte, i_clk, i_rst_n, w_res_push && w_res.out_valid && w_res.status != STAT_OK)
    // Finishing the head message with a byte always ends the read.
    `ASSERT_AT(a_done_is_last, i_clk, i_rst_n, (w_res_push && w_res.out_valid && w_res.message_done) |-> w_res.last)
    // With no closed message queued there is nothing pending.
    `ASSERT_AT(a_empty_no_pend, i_clk, i_rst_n, (w_res_push && w_res.queue_empty) |-> (w_res.pending_bytes == '0))

endmodule
